FILE: design/assert_macros.svh
// Assertion macros shared by the box filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr), msg)

`endif

FILE: design/bfb_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box filter
package bfb_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COL_SUM_W   = SAMPLE_W + 2;
    localparam int SUM_W       = SAMPLE_W + 4;
    localparam int DIV_W       = 4;
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int CFG_W       = 11;
    localparam int POS_W       = 10;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int TDATA_PAD_W = OUT_TDATA_W - SAMPLE_W - 2 * POS_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Register index taken from the word address
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Item kinds carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef struct packed {
        logic up;
        logic down;
    } rowmask_t;

    // ceil(2^RECIP_SHIFT / n): exact floor division for every numerator below 2^SUM_W
    function automatic logic [RECIP_W-1:0] recip_of(input logic [DIV_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd1:    r = RECIP_W'(25'd16777216);
            4'd2:    r = RECIP_W'(25'd8388608);
            4'd3:    r = RECIP_W'(25'd5592406);
            4'd4:    r = RECIP_W'(25'd4194304);
            4'd6:    r = RECIP_W'(25'd2796203);
            4'd9:    r = RECIP_W'(25'd1864136);
            default: r = RECIP_W'(25'd16777216);
        endcase
        return r;
    endfunction

endpackage

FILE: design/bfb_line_mem.sv
// Line buffer memory: one write port, one registered read port
module bfb_line_mem #(
    parameter int  DEPTH  = 1024,
    parameter int  DATA_W = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Hold the read word while the consumer stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bfb_win_cell.sv
// One column of the 3x3 window: three samples and their masked column sum
module bfb_win_cell (
    input  logic                           aclk,
    input  logic                           shift_en,
    input  logic [bfb_pkg::SAMPLE_W-1:0]   top_in,
    input  logic [bfb_pkg::SAMPLE_W-1:0]   mid_in,
    input  logic [bfb_pkg::SAMPLE_W-1:0]   bot_in,
    input  bfb_pkg::rowmask_t              rowmask,
    output logic [bfb_pkg::SAMPLE_W-1:0]   top_q,
    output logic [bfb_pkg::SAMPLE_W-1:0]   mid_q,
    output logic [bfb_pkg::SAMPLE_W-1:0]   bot_q,
    output logic [bfb_pkg::COL_SUM_W-1:0]  col_sum
);
    import bfb_pkg::*;

    logic [SAMPLE_W-1:0] top_reg;
    logic [SAMPLE_W-1:0] mid_reg;
    logic [SAMPLE_W-1:0] bot_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            top_reg <= top_in;
            mid_reg <= mid_in;
            bot_reg <= bot_in;
        end
    end

    assign top_q = top_reg;
    assign mid_q = mid_reg;
    assign bot_q = bot_reg;

    // Drop rows that fall outside the frame
    assign col_sum = (rowmask.up ? COL_SUM_W'(top_reg) : '0)
                   + COL_SUM_W'(mid_reg)
                   + (rowmask.down ? COL_SUM_W'(bot_reg) : '0);

endmodule

FILE: design/bfb_div.sv
// Mean: multiply the numerator by the reciprocal of the neighbour count and register the product
module bfb_div (
    input  logic                          aclk,
    input  logic                          load_en,
    input  logic [bfb_pkg::SUM_W-1:0]     numer,
    input  logic [bfb_pkg::DIV_W-1:0]     divisor,
    output logic [bfb_pkg::SAMPLE_W-1:0]  quotient
);
    import bfb_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(numer) * PROD_W'(recip_of(divisor));

    always_ff @(posedge aclk) begin
        if (load_en) begin
            prod_reg <= prod_next;
        end
    end

    assign quotient = prod_reg[RECIP_SHIFT +: SAMPLE_W];

endmodule

FILE: design/box_filter_3x3_bounded_top.sv
// Top level of the streaming 3x3 box filter with in-frame averaging at the borders
// The filter takes one slave transfer per clock unless back-pressure stalls it, and gives
// at most one master result per clock; a result passes line buffer read, window shift, sum
// and reciprocal multiply after the sample that completes its window, and the three middle
// stages plus the output register let new samples in while a result waits.
// Samples arrive in raster order, cols_in_use per row and rows_in_use per frame; the
// sample at raster index k releases the result for index k - cols - 1, and drain transfers
// (tuser set) after the frame flush the final cols + 1 results, the last one with tlast.
// Drains while samples are still due and samples after the frame is complete are taken
// and dropped. A register write restarts the frame and must be made while the block is
// idle. The two line buffers are not cleared after reset; entries not yet written only
// ever feed neighbours outside the frame.
`include "assert_macros.svh"

module box_filter_3x3_bounded_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bfb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bfb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bfb_pkg::SAMPLE_W-1:0]      s_tdata,  // [15:0] height_sample
    input  logic                              s_tuser,  // [0] operation
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] smoothed_height, [25:16] out_row, [35:26] out_col, [39:36] zero
    output logic [bfb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import bfb_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int REFF_W = $clog2(MAX_HEIGHT + 1);
    localparam int CMPC_W = (CEFF_W > CFG_W) ? CEFF_W : CFG_W;
    localparam int CMPR_W = (REFF_W > CFG_W) ? REFF_W : CFG_W;
    localparam int MEM_W  = 2 * SAMPLE_W;

    function automatic logic [CEFF_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [CMPC_W-1:0] vx;
        vx = CMPC_W'(v);
        if (v == '0) return CEFF_W'(1);
        if (vx > CMPC_W'(MAX_WIDTH)) return CEFF_W'(MAX_WIDTH);
        return CEFF_W'(vx);
    endfunction

    function automatic logic [REFF_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [CMPR_W-1:0] vx;
        vx = CMPR_W'(v);
        if (v == '0) return REFF_W'(1);
        if (vx > CMPR_W'(MAX_HEIGHT)) return REFF_W'(MAX_HEIGHT);
        return REFF_W'(vx);
    endfunction

    // ---------------- configuration ----------------
    logic [CFG_W-1:0]  cols_raw_reg, rows_raw_reg;
    logic [CEFF_W-1:0] cols_eff_reg;
    logic [REFF_W-1:0] rows_eff_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_ROWS) ? APB_DATA_W'(rows_raw_reg)
                                           : APB_DATA_W'(cols_raw_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_raw_reg <= CFG_RESET;
            rows_raw_reg <= CFG_RESET;
            cols_eff_reg <= clamp_cols(CFG_RESET);
            rows_eff_reg <= clamp_rows(CFG_RESET);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ROWS) begin
                rows_raw_reg <= pwdata[CFG_W-1:0];
                rows_eff_reg <= clamp_rows(pwdata[CFG_W-1:0]);
            end else begin
                cols_raw_reg <= pwdata[CFG_W-1:0];
                cols_eff_reg <= clamp_cols(pwdata[CFG_W-1:0]);
            end
        end
    end

    // ---------------- handshake chain ----------------
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, m_valid_reg;
    logic out_ready, p3_ready, p2_ready, p1_ready;
    logic p1_fire, p2_fire, p3_fire;

    assign out_ready = !m_valid_reg || m_tready;
    assign p3_ready  = !p3_valid_reg || out_ready;
    assign p2_ready  = !p2_valid_reg || p3_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign p1_fire   = p1_valid_reg && p2_ready;
    assign p2_fire   = p2_valid_reg && p3_ready;
    assign p3_fire   = p3_valid_reg && out_ready;
    assign s_tready  = p1_ready;

    // ---------------- raster counters ----------------
    logic [COL_W-1:0]  in_col_reg, out_col_reg, cols_last;
    logic [ROW_W-1:0]  in_row_reg;
    logic [OROW_W-1:0] out_row_reg, rows_last;
    logic              accept, frame_open, take, emit;
    logic              col_end, ocol_end, orow_end, last;
    logic              nb_left, nb_right;
    rowmask_t          nb_rows;
    logic [1:0]        rows_n, cols_n;
    logic [DIV_W-1:0]  nb_div;
    logic [SAMPLE_W-1:0] s_val;

    assign cols_last  = COL_W'(cols_eff_reg - 1'b1);
    assign rows_last  = OROW_W'(rows_eff_reg - 1'b1);
    assign accept     = s_tvalid && s_tready;
    assign frame_open = in_row_reg < ROW_W'(rows_eff_reg);
    // Drains count only once the frame is in; samples only while it is open
    assign take       = accept && (frame_open ? (s_tuser == OP_SAMPLE)
                                              : (s_tuser == OP_DRAIN));
    assign emit       = (in_row_reg > ROW_W'(1))
                     || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign col_end    = in_col_reg == cols_last;
    assign ocol_end   = out_col_reg == cols_last;
    assign orow_end   = out_row_reg == rows_last;
    assign last       = emit && ocol_end && orow_end;
    assign nb_rows.up   = out_row_reg != '0;
    assign nb_rows.down = !orow_end;
    assign nb_left    = out_col_reg != '0;
    assign nb_right   = !ocol_end;
    assign rows_n     = 2'd1 + 2'(nb_rows.up) + 2'(nb_rows.down);
    assign cols_n     = 2'd1 + 2'(nb_left) + 2'(nb_right);
    assign nb_div     = DIV_W'(rows_n) * DIV_W'(cols_n);
    assign s_val      = frame_open ? s_tdata : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_wr || (take && last)) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (take) begin
            in_col_reg <= col_end ? '0 : in_col_reg + 1'b1;
            if (col_end) begin
                in_row_reg <= in_row_reg + 1'b1;
            end
            if (emit) begin
                out_col_reg <= ocol_end ? '0 : out_col_reg + 1'b1;
                if (ocol_end) begin
                    out_row_reg <= out_row_reg + 1'b1;
                end
            end
        end
    end

    // ---------------- stage 1: line buffer read ----------------
    logic [COL_W-1:0]    p1_col_reg;
    logic [SAMPLE_W-1:0] p1_s_reg;
    logic                p1_emit_reg, p1_left_reg, p1_right_reg, p1_last_reg;
    rowmask_t            p1_rows_reg;
    logic [DIV_W-1:0]    p1_div_reg;
    logic [POS_W-1:0]    p1_orow_reg, p1_ocol_reg;
    logic                p1_byp_reg;
    logic [MEM_W-1:0]    p1_bypw_reg;
    logic [MEM_W-1:0]    mem_rdata, p1_rd, p1_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            p1_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            p1_col_reg   <= in_col_reg;
            p1_s_reg     <= s_val;
            p1_emit_reg  <= emit;
            p1_rows_reg  <= nb_rows;
            p1_left_reg  <= nb_left;
            p1_right_reg <= nb_right;
            p1_div_reg   <= nb_div;
            p1_orow_reg  <= POS_W'(out_row_reg);
            p1_ocol_reg  <= POS_W'(out_col_reg);
            p1_last_reg  <= last;
            // Forward the word written this cycle to the same column
            p1_byp_reg   <= p1_fire && (p1_col_reg == in_col_reg);
            p1_bypw_reg  <= p1_wdata;
        end
    end

    assign p1_rd    = p1_byp_reg ? p1_bypw_reg : mem_rdata;
    // Upper row takes the old middle row, middle row takes the new sample
    assign p1_wdata = {p1_rd[SAMPLE_W-1:0], p1_s_reg};

    bfb_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (MEM_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (p1_fire),
        .wr_addr (p1_col_reg),
        .wr_data (p1_wdata),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (mem_rdata)
    );

    // ---------------- window cells ----------------
    logic [SAMPLE_W-1:0]  feed_top [3];
    logic [SAMPLE_W-1:0]  feed_mid [3];
    logic [SAMPLE_W-1:0]  feed_bot [3];
    logic [SAMPLE_W-1:0]  cell_top [3];
    logic [SAMPLE_W-1:0]  cell_mid [3];
    logic [SAMPLE_W-1:0]  cell_bot [3];
    logic [COL_SUM_W-1:0] cell_sum [3];
    rowmask_t             p2_rows_reg;

    always_comb begin
        feed_top[2] = p1_rd[MEM_W-1:SAMPLE_W];
        feed_mid[2] = p1_rd[SAMPLE_W-1:0];
        feed_bot[2] = p1_s_reg;
        feed_top[1] = cell_top[2];
        feed_mid[1] = cell_mid[2];
        feed_bot[1] = cell_bot[2];
        feed_top[0] = cell_top[1];
        feed_mid[0] = cell_mid[1];
        feed_bot[0] = cell_bot[1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_cell
        bfb_win_cell u_cell (
            .aclk     (aclk),
            .shift_en (p1_fire),
            .top_in   (feed_top[i]),
            .mid_in   (feed_mid[i]),
            .bot_in   (feed_bot[i]),
            .rowmask  (p2_rows_reg),
            .top_q    (cell_top[i]),
            .mid_q    (cell_mid[i]),
            .bot_q    (cell_bot[i]),
            .col_sum  (cell_sum[i])
        );
    end

    // ---------------- stage 2: window sum ----------------
    logic             p2_left_reg, p2_right_reg, p2_last_reg;
    logic [DIV_W-1:0] p2_div_reg;
    logic [POS_W-1:0] p2_orow_reg, p2_ocol_reg;
    logic [SUM_W-1:0] p2_numer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_ready) begin
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_fire) begin
            p2_rows_reg  <= p1_rows_reg;
            p2_left_reg  <= p1_left_reg;
            p2_right_reg <= p1_right_reg;
            p2_div_reg   <= p1_div_reg;
            p2_orow_reg  <= p1_orow_reg;
            p2_ocol_reg  <= p1_ocol_reg;
            p2_last_reg  <= p1_last_reg;
        end
    end

    // Centre column sits in the middle cell; add half the count to round
    assign p2_numer = (p2_left_reg ? SUM_W'(cell_sum[0]) : '0)
                    + SUM_W'(cell_sum[1])
                    + (p2_right_reg ? SUM_W'(cell_sum[2]) : '0)
                    + SUM_W'(p2_div_reg >> 1);

    // ---------------- stage 3: divide ----------------
    logic [SUM_W-1:0]    p3_numer_reg;
    logic [DIV_W-1:0]    p3_div_reg;
    logic [POS_W-1:0]    p3_orow_reg, p3_ocol_reg, m_row_reg, m_col_reg;
    logic                p3_last_reg, m_last_reg;
    logic [SAMPLE_W-1:0] mean;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (p3_ready) begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= p3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_fire) begin
            p3_numer_reg <= p2_numer;
            p3_div_reg   <= p2_div_reg;
            p3_orow_reg  <= p2_orow_reg;
            p3_ocol_reg  <= p2_ocol_reg;
            p3_last_reg  <= p2_last_reg;
        end
        if (p3_fire) begin
            m_row_reg  <= p3_orow_reg;
            m_col_reg  <= p3_ocol_reg;
            m_last_reg <= p3_last_reg;
        end
    end

    bfb_div u_div (
        .aclk     (aclk),
        .load_en  (p3_fire),
        .numer    (p3_numer_reg),
        .divisor  (p3_div_reg),
        .quotient (mean)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{TDATA_PAD_W{1'b0}}, m_col_reg, m_row_reg, mean};
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_out_col_range, aclk, aresetn, CEFF_W'(out_col_reg) < cols_eff_reg, "output column counter beyond row width")
    `ASSERT_CLK(a_out_row_range, aclk, aresetn, REFF_W'(out_row_reg) < rows_eff_reg, "output row counter beyond frame height")
    `ASSERT_NEVER(a_in_row_range, aclk, aresetn, in_row_reg > ROW_W'(rows_eff_reg) + ROW_W'(1), "input row counter ran past the drain")
    `ASSERT_CLK(a_div_count, aclk, aresetn, p3_valid_reg |-> (p3_div_reg == DIV_W'(1) || p3_div_reg == DIV_W'(2) || p3_div_reg == DIV_W'(3) || p3_div_reg == DIV_W'(4) || p3_div_reg == DIV_W'(6) || p3_div_reg == DIV_W'(9)), "neighbour count not a valid box size")

endmodule
